[rtl/core/gcpl_pkg.sv]
// Shared constants, types and helper functions for the great-circle path length core.
package gcpl_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int DIV_BITS         = 30;

  // Configuration register indexes (byte address / 4)
  typedef enum logic [2:0] {
    CFG_CENTER_X       = 3'd0,
    CFG_CENTER_Y       = 3'd1,
    CFG_CENTER_Z       = 3'd2,
    CFG_SPHERE_RADIUS  = 3'd3,
    CFG_ADD_APPROACHES = 3'd4
  } cfg_idx_t;

  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [61:0] Q60_ONE      = 62'h1000_0000_0000_0000;
  localparam logic [30:0] Q30_HALF_PI  = 31'd1686629713;
  localparam logic [31:0] Q30_PI       = 32'd3373259426;
  localparam logic [30:0] RADIUS_RESET = 31'd65536;
  localparam logic [63:0] ROUND_HALF   = 64'd536870912;

  localparam logic signed [41:0] PATH_MAX_Q = 42'sd549755813887;
  localparam logic signed [41:0] PATH_MIN_Q = -42'sd549755813888;

  typedef struct packed {
    logic [39:0] route_len;
    logic        degenerate;
    logic        overflowed;
  } result_t;

  // Magnitude of a 33-bit two's complement ray component; always fits 32 bits
  function automatic logic [31:0] ray_mag(input logic [32:0] v);
    logic [32:0] a;
    a = v[32] ? (~v + 33'd1) : v;
    return a[31:0];
  endfunction

  // atan(2^-i) in Q0.30, truncated toward zero
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] t;
    case (i)
      5'd0:  t = 30'd843314856;
      5'd1:  t = 30'd497837829;
      5'd2:  t = 30'd263043836;
      5'd3:  t = 30'd133525158;
      5'd4:  t = 30'd67021686;
      5'd5:  t = 30'd33543515;
      5'd6:  t = 30'd16775850;
      5'd7:  t = 30'd8388437;
      5'd8:  t = 30'd4194282;
      5'd9:  t = 30'd2097149;
      5'd10: t = 30'd1048575;
      5'd11: t = 30'd524287;
      5'd12: t = 30'd262143;
      5'd13: t = 30'd131071;
      5'd14: t = 30'd65535;
      5'd15: t = 30'd32767;
      5'd16: t = 30'd16383;
      5'd17: t = 30'd8191;
      5'd18: t = 30'd4095;
      5'd19: t = 30'd2047;
      5'd20: t = 30'd1023;
      5'd21: t = 30'd511;
      5'd22: t = 30'd255;
      5'd23: t = 30'd127;
      5'd24: t = 30'd63;
      5'd25: t = 30'd31;
      5'd26: t = 30'd15;
      5'd27: t = 30'd7;
      5'd28: t = 30'd3;
      5'd29: t = 30'd1;
      default: t = 30'd0;
    endcase
    return t;
  endfunction

endpackage

[rtl/core/gcpl_isqrt.sv]
// Pipelined floor square root, one result bit per stage, with a sideband carried alongside.
module gcpl_isqrt #(
  parameter int QW = 66,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [QW-1:0]     in_q,
  input  logic [SW-1:0]     in_sb,
  output logic              out_v,
  output logic [QW/2-1:0]   out_root,
  output logic [SW-1:0]     out_sb
);

  localparam int RW = QW / 2;

  logic            v_r    [RW];
  logic [RW:0]     rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [QW-1:0]   q_r    [RW];
  logic [SW-1:0]   sb_r   [RW];

  genvar k;
  for (k = 0; k < RW; k++) begin : g_step
    logic          v_in;
    logic [RW:0]   rem_in;
    logic [RW-1:0] root_in;
    logic [QW-1:0] q_in;
    logic [SW-1:0] sb_in;
    logic [RW+2:0] rem_t;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;

    if (k == 0) begin : g_first
      assign v_in    = in_v;
      assign rem_in  = '0;
      assign root_in = '0;
      assign q_in    = in_q;
      assign sb_in   = in_sb;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign q_in    = q_r[k-1];
      assign sb_in   = sb_r[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1
    assign rem_t = {rem_in, q_in[QW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = rem_t - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]  <= {q_in[QW-3:0], 2'b00};
        sb_r[k] <= sb_in;
        if (rem_t >= trial) begin
          rem_r[k]  <= diff[RW:0];
          root_r[k] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_t[RW:0];
          root_r[k] <= {root_in[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_v    = v_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_sb   = sb_r[RW-1];

endmodule

[rtl/core/great_circle_path_length_core.sv]
// Top level of the great-circle path length core: config registers, pipeline, output buffer.
//
// Accepts one point pair per clock while the pipeline is not held and returns one path length
// per pair, in order. The delay from an accepted pair to its result comes mostly from the two
// bit-serial square roots (33 and 31 stages), the 30-stage restoring divider for the cosine
// and the CORDIC chain, one stage per iteration. A two-entry output buffer lets the pipeline
// keep accepting pairs while one finished result waits; the whole pipeline holds only when
// that buffer is full, the last stage holds a result and out_ready is low. The user must write
// configuration through the APB-style port only while no pair is in flight (not enforced).
module great_circle_path_length_core
  import gcpl_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input pair transaction
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_first_x,
  input  logic [31:0] in_first_y,
  input  logic [31:0] in_first_z,
  input  logic [31:0] in_second_x,
  input  logic [31:0] in_second_y,
  input  logic [31:0] in_second_z,
  // result transaction
  output logic        out_valid,
  input  logic        out_ready,
  output logic [39:0] out_route_len,
  output logic        out_degenerate,
  output logic        out_overflowed,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------- config
  logic [31:0] center_x_r, center_y_r, center_z_r;
  logic [30:0] radius_r;
  logic        add_appr_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Latch register writes; ignore addresses past the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      radius_r   <= RADIUS_RESET;
      add_appr_r <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        CFG_CENTER_X:       center_x_r <= pwdata;
        CFG_CENTER_Y:       center_y_r <= pwdata;
        CFG_CENTER_Z:       center_z_r <= pwdata;
        CFG_SPHERE_RADIUS:  radius_r   <= pwdata[30:0];
        CFG_ADD_APPROACHES: add_appr_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[4:2])
      CFG_CENTER_X:       prdata = center_x_r;
      CFG_CENTER_Y:       prdata = center_y_r;
      CFG_CENTER_Z:       prdata = center_z_r;
      CFG_SPHERE_RADIUS:  prdata = {1'b0, radius_r};
      CFG_ADD_APPROACHES: prdata = {31'd0, add_appr_r};
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  logic    en;
  logic    v12_r;
  logic [1:0] cnt_r;
  assign en       = !v12_r || (cnt_r != 2'd2) || out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------- S1: rays
  logic [32:0] r1_r [3];
  logic [32:0] r2_r [3];
  logic        v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r[0] <= {in_first_x[31], in_first_x}   - {center_x_r[31], center_x_r};
      r1_r[1] <= {in_first_y[31], in_first_y}   - {center_y_r[31], center_y_r};
      r1_r[2] <= {in_first_z[31], in_first_z}   - {center_z_r[31], center_z_r};
      r2_r[0] <= {in_second_x[31], in_second_x} - {center_x_r[31], center_x_r};
      r2_r[1] <= {in_second_y[31], in_second_y} - {center_y_r[31], center_y_r};
      r2_r[2] <= {in_second_z[31], in_second_z} - {center_z_r[31], center_z_r};
    end
  end

  // ---------------------------------------------------------------- S2: products
  logic [63:0] sq1p_r [3];
  logic [63:0] sq2p_r [3];
  logic [63:0] dotp_r [3];
  logic [2:0]  xneg_r;
  logic        v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq1p_r[i] <= ray_mag(r1_r[i]) * ray_mag(r1_r[i]);
        sq2p_r[i] <= ray_mag(r2_r[i]) * ray_mag(r2_r[i]);
        dotp_r[i] <= ray_mag(r1_r[i]) * ray_mag(r2_r[i]);
        xneg_r[i] <= r1_r[i][32] ^ r2_r[i][32];
      end
    end
  end

  // ---------------------------------------------------------------- S3: sums
  logic [65:0] sq1_r, sq2_r, pos_r, neg_r;
  logic        v3_r;
  logic [65:0] pos_nxt, neg_nxt;

  always_comb begin
    pos_nxt = '0;
    neg_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (xneg_r[i]) neg_nxt = neg_nxt + {2'b00, dotp_r[i]};
      else           pos_nxt = pos_nxt + {2'b00, dotp_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq1_r <= {2'b00, sq1p_r[0]} + {2'b00, sq1p_r[1]} + {2'b00, sq1p_r[2]};
      sq2_r <= {2'b00, sq2p_r[0]} + {2'b00, sq2p_r[1]} + {2'b00, sq2p_r[2]};
      pos_r <= pos_nxt;
      neg_r <= neg_nxt;
    end
  end

  // ---------------------------------------------------------------- S4: |dot| and sign
  logic [65:0] adot4_r, sq1_4_r, sq2_4_r;
  logic        dneg4_r;
  logic        v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dneg4_r <= neg_r > pos_r;
      adot4_r <= (neg_r > pos_r) ? (neg_r - pos_r) : (pos_r - neg_r);
      sq1_4_r <= sq1_r;
      sq2_4_r <= sq2_r;
    end
  end

  // ---------------------------------------------------------------- norms
  logic        va5, vb5;
  logic [32:0] n1_5, n2_5;
  logic [65:0] adot5;
  logic        dneg5;

  gcpl_isqrt #(.QW(66), .SW(66)) u_norm1 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(v4_r), .in_q(sq1_4_r), .in_sb(adot4_r),
    .out_v(va5), .out_root(n1_5), .out_sb(adot5)
  );

  gcpl_isqrt #(.QW(66), .SW(1)) u_norm2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(v4_r), .in_q(sq2_4_r), .in_sb(dneg4_r),
    .out_v(vb5), .out_root(n2_5), .out_sb(dneg5)
  );

  // ---------------------------------------------------------------- S6: denominator
  logic [65:0] den6_r, adot6_r;
  logic [32:0] n1_6_r, n2_6_r;
  logic        dneg6_r, degen6_r, v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= va5 && vb5;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den6_r   <= n1_5 * n2_5;
      adot6_r  <= adot5;
      n1_6_r   <= n1_5;
      n2_6_r   <= n2_5;
      dneg6_r  <= dneg5;
      degen6_r <= (n1_5 == '0) || (n2_5 == '0);
    end
  end

  // ---------------------------------------------------------------- S7: clamp test
  logic [65:0] den7_r, adot7_r;
  logic [32:0] n1_7_r, n2_7_r;
  logic        dneg7_r, degen7_r, clamp7_r, v7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en) v7_r <= v6_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clamp7_r <= adot6_r >= den6_r;
      den7_r   <= den6_r;
      adot7_r  <= adot6_r;
      n1_7_r   <= n1_6_r;
      n2_7_r   <= n2_6_r;
      dneg7_r  <= dneg6_r;
      degen7_r <= degen6_r;
    end
  end

  // ---------------------------------------------------------------- cosine divider
  logic          dv_r     [DIV_BITS];
  logic [65:0]   drem_r   [DIV_BITS];
  logic [65:0]   dden_r   [DIV_BITS];
  logic [DIV_BITS-1:0] dq_r [DIV_BITS];
  logic [32:0]   dn1_r    [DIV_BITS];
  logic [32:0]   dn2_r    [DIV_BITS];
  logic          ddneg_r  [DIV_BITS];
  logic          ddegen_r [DIV_BITS];
  logic          dclamp_r [DIV_BITS];

  genvar d;
  for (d = 0; d < DIV_BITS; d++) begin : g_div
    logic          v_in, dneg_in, degen_in, clamp_in;
    logic [65:0]   rem_in, den_in;
    logic [DIV_BITS-1:0] q_in;
    logic [32:0]   n1_in, n2_in;
    logic [66:0]   rs, diff;

    if (d == 0) begin : g_first
      assign v_in     = v7_r;
      assign rem_in   = adot7_r;
      assign den_in   = den7_r;
      assign q_in     = '0;
      assign n1_in    = n1_7_r;
      assign n2_in    = n2_7_r;
      assign dneg_in  = dneg7_r;
      assign degen_in = degen7_r;
      assign clamp_in = clamp7_r;
    end else begin : g_next
      assign v_in     = dv_r[d-1];
      assign rem_in   = drem_r[d-1];
      assign den_in   = dden_r[d-1];
      assign q_in     = dq_r[d-1];
      assign n1_in    = dn1_r[d-1];
      assign n2_in    = dn2_r[d-1];
      assign dneg_in  = ddneg_r[d-1];
      assign degen_in = ddegen_r[d-1];
      assign clamp_in = dclamp_r[d-1];
    end

    // Shift the remainder and subtract the denominator when it fits
    assign rs   = {rem_in, 1'b0};
    assign diff = rs - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[d] <= 1'b0;
      else if (en) dv_r[d] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dden_r[d]   <= den_in;
        dn1_r[d]    <= n1_in;
        dn2_r[d]    <= n2_in;
        ddneg_r[d]  <= dneg_in;
        ddegen_r[d] <= degen_in;
        dclamp_r[d] <= clamp_in;
        if (rs >= {1'b0, den_in}) begin
          drem_r[d] <= diff[65:0];
          dq_r[d]   <= {q_in[DIV_BITS-2:0], 1'b1};
        end else begin
          drem_r[d] <= rs[65:0];
          dq_r[d]   <= {q_in[DIV_BITS-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------- S8: cos squared
  logic [30:0] c8_r;
  logic [61:0] csq8_r;
  logic [32:0] n1_8_r, n2_8_r;
  logic        dneg8_r, degen8_r, v8_r;
  logic [30:0] cos_div;

  assign cos_div = dclamp_r[DIV_BITS-1] ? Q30_ONE : {1'b0, dq_r[DIV_BITS-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (en) v8_r <= dv_r[DIV_BITS-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c8_r     <= cos_div;
      csq8_r   <= cos_div * cos_div;
      n1_8_r   <= dn1_r[DIV_BITS-1];
      n2_8_r   <= dn2_r[DIV_BITS-1];
      dneg8_r  <= ddneg_r[DIV_BITS-1];
      degen8_r <= ddegen_r[DIV_BITS-1];
    end
  end

  // ---------------------------------------------------------------- S9: 1 - cos^2
  logic [30:0] c9_r;
  logic [61:0] t9_r;
  logic [32:0] n1_9_r, n2_9_r;
  logic        dneg9_r, degen9_r, v9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else if (en) v9_r <= v8_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t9_r     <= Q60_ONE - csq8_r;
      c9_r     <= c8_r;
      n1_9_r   <= n1_8_r;
      n2_9_r   <= n2_8_r;
      dneg9_r  <= dneg8_r;
      degen9_r <= degen8_r;
    end
  end

  // ---------------------------------------------------------------- sine
  localparam int SIN_SB = 31 + 33 + 33 + 2;
  logic              vs;
  logic [30:0]       sin_s;
  logic [SIN_SB-1:0] sin_sb;
  logic [30:0]       cs;
  logic [32:0]       cn1, cn2;
  logic              cdneg, cdegen;

  gcpl_isqrt #(.QW(62), .SW(SIN_SB)) u_sine (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(v9_r), .in_q(t9_r),
    .in_sb({c9_r, n1_9_r, n2_9_r, dneg9_r, degen9_r}),
    .out_v(vs), .out_root(sin_s), .out_sb(sin_sb)
  );

  assign {cs, cn1, cn2, cdneg, cdegen} = sin_sb;

  // ---------------------------------------------------------------- CORDIC vectoring
  logic               kv_r     [CORDIC_STEPS];
  logic signed [33:0] kx_r     [CORDIC_STEPS];
  logic signed [33:0] ky_r     [CORDIC_STEPS];
  logic signed [32:0] kz_r     [CORDIC_STEPS];
  logic [32:0]        kn1_r    [CORDIC_STEPS];
  logic [32:0]        kn2_r    [CORDIC_STEPS];
  logic               kdneg_r  [CORDIC_STEPS];
  logic               kdegen_r [CORDIC_STEPS];

  genvar c;
  for (c = 0; c < CORDIC_STEPS; c++) begin : g_cordic
    logic               v_in, dneg_in, degen_in;
    logic signed [33:0] x_in, y_in, xs, ys;
    logic signed [32:0] z_in, t;
    logic [32:0]        n1_in, n2_in;

    if (c == 0) begin : g_first
      assign v_in     = vs;
      assign x_in     = {3'b000, cs};
      assign y_in     = {3'b000, sin_s};
      assign z_in     = '0;
      assign n1_in    = cn1;
      assign n2_in    = cn2;
      assign dneg_in  = cdneg;
      assign degen_in = cdegen;
    end else begin : g_next
      assign v_in     = kv_r[c-1];
      assign x_in     = kx_r[c-1];
      assign y_in     = ky_r[c-1];
      assign z_in     = kz_r[c-1];
      assign n1_in    = kn1_r[c-1];
      assign n2_in    = kn2_r[c-1];
      assign dneg_in  = kdneg_r[c-1];
      assign degen_in = kdegen_r[c-1];
    end

    assign xs = x_in >>> c;
    assign ys = y_in >>> c;
    assign t  = {3'b000, atan_q30(5'(c))};

    always_ff @(posedge clk) begin
      if (!rst_n) kv_r[c] <= 1'b0;
      else if (en) kv_r[c] <= v_in;
    end

    // Rotate toward the x axis and accumulate the angle
    always_ff @(posedge clk) begin
      if (en) begin
        kn1_r[c]    <= n1_in;
        kn2_r[c]    <= n2_in;
        kdneg_r[c]  <= dneg_in;
        kdegen_r[c] <= degen_in;
        if (!y_in[33]) begin
          kx_r[c] <= x_in + ys;
          ky_r[c] <= y_in - xs;
          kz_r[c] <= z_in + t;
        end else begin
          kx_r[c] <= x_in - ys;
          ky_r[c] <= y_in + xs;
          kz_r[c] <= z_in - t;
        end
      end
    end
  end

  // ---------------------------------------------------------------- S10: angle
  logic [31:0] angle10_r;
  logic [32:0] n1_10_r, n2_10_r;
  logic        degen10_r, v10_r;
  logic signed [32:0] zf;
  logic [30:0] zc;

  assign zf = kz_r[CORDIC_STEPS-1];

  always_comb begin
    if (zf[32])                                    zc = '0;
    else if (zf > $signed({2'b00, Q30_HALF_PI}))   zc = Q30_HALF_PI;
    else                                           zc = zf[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v10_r <= 1'b0;
    else if (en) v10_r <= kv_r[CORDIC_STEPS-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (kdegen_r[CORDIC_STEPS-1])       angle10_r <= '0;
      else if (kdneg_r[CORDIC_STEPS-1])   angle10_r <= Q30_PI - {1'b0, zc};
      else                                angle10_r <= {1'b0, zc};
      n1_10_r   <= kn1_r[CORDIC_STEPS-1];
      n2_10_r   <= kn2_r[CORDIC_STEPS-1];
      degen10_r <= kdegen_r[CORDIC_STEPS-1];
    end
  end

  // ---------------------------------------------------------------- S11: radius * angle
  logic [62:0] prod11_r;
  logic [32:0] n1_11_r, n2_11_r;
  logic        degen11_r, v11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v11_r <= 1'b0;
    else if (en) v11_r <= v10_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod11_r  <= radius_r * angle10_r;
      n1_11_r   <= n1_10_r;
      n2_11_r   <= n2_10_r;
      degen11_r <= degen10_r;
    end
  end

  // ---------------------------------------------------------------- S12: sum and saturate
  result_t     res12_r;
  logic [63:0] rnd;
  logic [41:0] appr, dsum;

  assign rnd  = {1'b0, prod11_r} + ROUND_HALF;
  assign appr = {9'd0, n1_11_r} + {9'd0, n2_11_r} - {10'd0, radius_r, 1'b0};
  assign dsum = {8'd0, rnd[63:30]} + (add_appr_r ? appr : 42'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) v12_r <= 1'b0;
    else if (en) v12_r <= v11_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res12_r.degenerate <= degen11_r;
      if ($signed(dsum) > PATH_MAX_Q) begin
        res12_r.route_len  <= PATH_MAX_Q[39:0];
        res12_r.overflowed <= 1'b1;
      end else if ($signed(dsum) < PATH_MIN_Q) begin
        res12_r.route_len  <= PATH_MIN_Q[39:0];
        res12_r.overflowed <= 1'b1;
      end else begin
        res12_r.route_len  <= dsum[39:0];
        res12_r.overflowed <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- output buffer
  result_t    fifo_r [2];
  logic       wp_r, rp_r;
  logic       push, pop;
  logic [1:0] cnt_nxt;

  assign push    = v12_r && en;
  assign pop     = out_valid && out_ready;
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= res12_r;
  end

  assign out_valid      = cnt_r != 2'd0;
  assign out_route_len  = fifo_r[rp_r].route_len;
  assign out_degenerate = fifo_r[rp_r].degenerate;
  assign out_overflowed = fifo_r[rp_r].overflowed;

endmodule

[rtl/core/gcpl_checker.sv]
// Port-level assertions for the great-circle path length core, with its bind.
module gcpl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [39:0] out_route_len,
  input logic        out_degenerate,
  input logic        out_overflowed,
  input logic        pready
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_route_len)
      && $stable(out_degenerate) && $stable(out_overflowed))
    else $error("result changed while stalled");

  // Saturated result sits on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflowed |->
      out_route_len == 40'h7F_FFFF_FFFF || out_route_len == 40'h80_0000_0000)
    else $error("overflow flagged without saturated value");

  // Reset drains the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind great_circle_path_length_core gcpl_checker u_gcpl_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for the great-circle path length core.
module tb_top
  import gcpl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS     = 24;
  localparam int LATENCY   = 106 + STEPS;
  localparam int N_SETTING = 6;
  localparam int PER_SET   = 175;
  localparam int N_DIR     = 12;

  typedef logic [31:0] pair_t [6];

  // Predicts path results and holds them until the core returns them
  class path_scoreboard;
    result_t          pending[$];
    logic signed [31:0] ctr[3];
    logic [30:0]      radius;
    logic             approach;
    longint           atan_tab[STEPS];
    int               mismatches;

    function new();
      longint tab[30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                          33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                          524287, 262143, 131071, 65535, 32767, 16383, 8191, 4095,
                          2047, 1023, 511, 255, 127, 63, 31, 15, 7, 3, 1};
      for (int i = 0; i < STEPS; i++) atan_tab[i] = (i < 30) ? tab[i] : 0;
      ctr = '{0, 0, 0};
      radius = RADIUS_RESET;
      approach = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_CENTER_X:       ctr[0] = v;
        CFG_CENTER_Y:       ctr[1] = v;
        CFG_CENTER_Z:       ctr[2] = v;
        CFG_SPHERE_RADIUS:  radius = v[30:0];
        CFG_ADD_APPROACHES: approach = v[0];
        default: ;
      endcase
    endfunction

    // floor(sqrt(q)) for q below 2^70
    function logic [63:0] isqrt(logic [127:0] q);
      logic [63:0] r;
      logic [63:0] cand;
      r = 0;
      for (int b = 34; b >= 0; b--) begin
        cand = r | (64'd1 << b);
        if ({64'd0, cand} * {64'd0, cand} <= q) r = cand;
      end
      return r;
    endfunction

    function result_t path_of(pair_t p);
      longint      r1[3], r2[3];
      logic [63:0] m1, m2, n1, n2, c, s, ang, arc;
      logic [127:0] pos, neg, adot, den, q1, q2, prod, t;
      longint      x, y, z, xs, ys, d;
      bit          dneg, degen;
      result_t     res;
      pos = 0; neg = 0; q1 = 0; q2 = 0; ang = 0;
      for (int k = 0; k < 3; k++) begin
        r1[k] = longint'($signed(p[k])) - longint'(ctr[k]);
        r2[k] = longint'($signed(p[k+3])) - longint'(ctr[k]);
        m1 = (r1[k] < 0) ? -r1[k] : r1[k];
        m2 = (r2[k] < 0) ? -r2[k] : r2[k];
        prod = {64'd0, m1} * {64'd0, m2};
        if ((r1[k] < 0) != (r2[k] < 0)) neg += prod;
        else pos += prod;
        q1 += {64'd0, m1} * {64'd0, m1};
        q2 += {64'd0, m2} * {64'd0, m2};
      end
      dneg = neg > pos;
      adot = dneg ? neg - pos : pos - neg;
      n1 = isqrt(q1);
      n2 = isqrt(q2);
      degen = (n1 == 0) || (n2 == 0);
      if (!degen) begin
        den = {64'd0, n1} * {64'd0, n2};
        if (adot >= den) c = 64'd1 << 30;
        else c = 64'((adot << 30) / den);
        t = (128'd1 << 60) - {64'd0, c} * {64'd0, c};
        s = isqrt(t);
        // vector the (cos, sin) pair onto the x axis
        x = c; y = s; z = 0;
        for (int i = 0; i < STEPS; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x += ys; y -= xs; z += atan_tab[i];
          end else begin
            x -= ys; y += xs; z -= atan_tab[i];
          end
        end
        if (z < 0) z = 0;
        if (z > longint'(Q30_HALF_PI)) z = Q30_HALF_PI;
        ang = dneg ? longint'(Q30_PI) - z : z;
      end
      arc = (ang * 64'(radius) + 64'd536870912) >> 30;
      d = arc;
      if (approach) d += longint'(n1) + longint'(n2) - 2 * longint'(radius);
      res.overflowed = 1'b0;
      if (d > longint'(PATH_MAX_Q)) begin
        d = PATH_MAX_Q; res.overflowed = 1'b1;
      end
      if (d < longint'(PATH_MIN_Q)) begin
        d = PATH_MIN_Q; res.overflowed = 1'b1;
      end
      res.route_len = d[39:0];
      res.degenerate = degen;
      return res;
    endfunction

    function void note_pair(pair_t p);
      pending = {pending, path_of(p)};
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected len=%0d degen=%0b ovf=%0b, %s",
                   $signed(exp_r.route_len), exp_r.degenerate, exp_r.overflowed,
                   $sformatf("got len=%0d degen=%0b ovf=%0b",
                             $signed(got.route_len), got.degenerate, got.overflowed));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_first_x = '0, in_first_y = '0, in_first_z = '0;
  logic [31:0] in_second_x = '0, in_second_y = '0, in_second_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [39:0] out_route_len;
  logic        out_degenerate, out_overflowed;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int send_idle = 0;
  int recv_idle = 0;
  path_scoreboard sb = new();

  great_circle_path_length_core u_top (.*);

  always #1 clk = ~clk;

  // Stall the result side at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Record accepted pairs and check returned results
  always @(posedge clk) begin
    pair_t p;
    result_t got;
    if (rst_n && in_valid && in_ready) begin
      p = '{in_first_x, in_first_y, in_first_z, in_second_x, in_second_y, in_second_z};
      sb.note_pair(p);
    end
    if (rst_n && out_valid && out_ready) begin
      got.route_len = out_route_len;
      got.degenerate = out_degenerate;
      got.overflowed = out_overflowed;
      sb.check_result(got);
    end
  end

  // Hold a pair until accepted; afterwards valid stays high unless a random idle draw drops it
  task automatic send_pair(pair_t p);
    in_valid <= 1'b1;
    {in_first_x, in_first_y, in_first_z} <= {p[0], p[1], p[2]};
    {in_second_x, in_second_y, in_second_z} <= {p[3], p[4], p[5]};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic drain();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(idx) << 2; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, v);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] extreme();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'h0000_0001;
      default: return 32'h0001_0000;
    endcase
  endfunction

  // Build a pair aimed at one corner of the behavior
  function automatic pair_t rand_pair();
    pair_t p;
    int    kind;
    int    off;
    kind = $urandom_range(6);
    for (int k = 0; k < 6; k++) begin
      off = int'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
      case (kind)
        0, 1: p[k] = $urandom;
        2:    p[k] = sb.ctr[k % 3] + off;
        default: p[k] = extreme();
      endcase
    end
    case (kind)
      3: for (int k = 0; k < 3; k++) p[k + 3 * $urandom_range(1)] = sb.ctr[k];
      4: for (int k = 0; k < 3; k++)
           p[k+3] = sb.ctr[k] + ((p[k] - sb.ctr[k]) <<< $urandom_range(1));
      5: for (int k = 0; k < 3; k++) p[k+3] = 2 * sb.ctr[k] - p[k];
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    pair_t dir[N_DIR];
    logic [31:0] setting[N_SETTING][5];
    dir[0]  = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    dir[1]  = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    dir[2]  = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    dir[3]  = '{0, 0, 0, 0, 0, 0};
    dir[4]  = '{0, 0, 0, 32'h0001_0000, 0, 0};
    dir[5]  = '{32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0};
    dir[6]  = '{32'h0001_0000, 0, 0, 32'hffff_0000, 0, 0};
    dir[7]  = '{32'h0001_0000, 0, 0, 32'h0005_0000, 0, 0};
    dir[8]  = '{32'h0000_0001, 0, 0, 0, 0, 32'hffff_ffff};
    dir[9]  = '{32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000, 0, 0};
    dir[10] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001,
                32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
    dir[11] = '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa};
    setting[0] = '{0, 0, 0, 32'h7fff_ffff, 1};
    setting[1] = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 1};
    setting[2] = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8001_0000, 0};
    setting[3] = '{32'h0003_0000, 32'hfffe_0000, 32'h0000_8000, 32'h0002_0000, 1};
    setting[4] = '{$urandom, $urandom, $urandom, $urandom, 32'hffff_fffe};
    setting[5] = '{$urandom, $urandom, $urandom, $urandom, 32'hffff_ffff};

    // Apply reset, then run the directed pairs at reset configuration and again with approaches added
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir[i]) send_pair(dir[i]);
    drain();
    write_reg(CFG_ADD_APPROACHES, 1);
    foreach (dir[i]) send_pair(dir[i]);
    drain();

    // Random pairs under each configuration, rotating the idle pattern
    for (int s = 0; s < N_SETTING; s++) begin
      for (int r = 0; r < 5; r++) write_reg(cfg_idx_t'(r), setting[s][r]);
      for (int i = 0; i < PER_SET; i++) begin
        case ((s * PER_SET + i) * 3 / (N_SETTING * PER_SET))
          0: begin send_idle = 26; recv_idle = 60; end
          1: begin send_idle = 60; recv_idle = 26; end
          default: begin send_idle = 0; recv_idle = 0; end
        endcase
        if (s == 1 && i == PER_SET / 2) drain();
        send_pair(rand_pair());
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
